// File: rtl/dpfrc_pkg.sv
// ----------------------------------------------------------------------------
// Packet FIFO with duplicate filter and range count: shared definitions
// Types, operation codes and constants used by the cells, the channels and
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfrc_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int OP_W          = 2;
   localparam int ID_W          = 16;
   localparam int STAMP_W       = 32;
   localparam int LIMIT_W       = 7;
   localparam int MATCH_W       = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [MATCH_W-1:0] COUNT_MAX   = 7'd127;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 2'd0,
      OP_FORWARD = 2'd1,
      OP_COUNT   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SCAN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    src;
      logic [ID_W-1:0]    dst;
      logic [STAMP_W-1:0] stamp;
   } packet_type;

   typedef struct packed {
      packet_type         pkt;
      logic [STAMP_W-1:0] range_start;
      logic [STAMP_W-1:0] range_end;
   } query_type;

   typedef struct packed {
      logic shift;
      logic capture;
      logic hit_shift;
      logic count_mode;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/dpfrc_if.sv
// ----------------------------------------------------------------------------
// Packet FIFO channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpfrc_req_if
   import dpfrc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [ID_W-1:0]    src_id;
   logic [ID_W-1:0]    dst_id;
   logic [STAMP_W-1:0] stamp;
   logic [STAMP_W-1:0] range_start;
   logic [STAMP_W-1:0] range_end;

   modport source (output valid, operation, src_id, dst_id, stamp, range_start, range_end,
                   input ready);
   modport sink (input valid, operation, src_id, dst_id, stamp, range_start, range_end,
                 output ready);
endinterface

interface dpfrc_rsp_if
   import dpfrc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               present;
   logic [ID_W-1:0]    out_src;
   logic [ID_W-1:0]    out_dst;
   logic [STAMP_W-1:0] out_stamp;
   logic [MATCH_W-1:0] match_count;

   modport source (output valid, accepted, present, out_src, out_dst, out_stamp, match_count,
                   input ready);
   modport sink (input valid, accepted, present, out_src, out_dst, out_stamp, match_count,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/dpfrc_cell.sv
// ----------------------------------------------------------------------------
// Packet FIFO storage cell
// Holds one packet, compares it against the broadcast query and passes its
// packet and its hit flag to the neighbor on the head side.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfrc_cell
   import dpfrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          load,
   input  wire query_type     query,
   input  wire logic          next_valid,
   input  wire packet_type    next_pkt,
   input  wire logic          next_hit,
   output logic               valid,
   output packet_type         pkt,
   output logic               hit
);

   logic       valid_ff, valid_in;
   logic       hit_ff, hit_in;
   packet_type pkt_ff, pkt_in;
   logic       match;

   always_comb begin
      if (ctrl.count_mode) begin
         match = (pkt_ff.dst == query.pkt.dst) &&
                 (pkt_ff.stamp >= query.range_start) &&
                 (pkt_ff.stamp <= query.range_end);
      end else begin
         match = (pkt_ff == query.pkt);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      pkt_in   = pkt_ff;
      hit_in   = hit_ff;
      if (load) begin
         valid_in = 1'b1;
         pkt_in   = query.pkt;
      end else if (ctrl.shift) begin
         valid_in = next_valid;
         pkt_in   = next_pkt;
      end
      if (ctrl.capture) begin
         hit_in = valid_ff && match;
      end else if (ctrl.hit_shift) begin
         hit_in = next_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign valid = valid_ff;
   assign pkt   = pkt_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire

// File: rtl/dedup_packet_fifo_range_count_core.sv
// ----------------------------------------------------------------------------
// Packet FIFO with duplicate filter and range count
// Bounded FIFO of packets kept in a row of cells, oldest packet at the head.
// ----------------------------------------------------------------------------
// The request channel carries one command per transfer: add a packet, forward
// the oldest packet, or count packets by destination and timestamp range. The
// response channel returns exactly one result per command, in order.
// The CSR port writes the packet limit; a write takes effect at once.
// A forward reads the head cell and shifts the row; its result is valid once
// the finish step loads the output register. An add or a count captures a hit
// flag in every cell in the compare step, then shifts the flags out of the head
// into a counter in the scan step; the commit and finish steps then load its
// result into the output register. A new request is taken only when the block
// is idle, so each command is finished before the next one is taken.
// Reset empties the FIFO and sets the limit to 64, clamped to DEPTH.
// The result sits in an output register. While the receiver stalls, a finished
// command waits until the register frees, and no further request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_packet_fifo_range_count_core
   import dpfrc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [LIMIT_W-1:0] csr_write_data,
   dpfrc_req_if.sink               req_if,
   dpfrc_rsp_if.source             rsp_if
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);
   localparam int LW = (FW > LIMIT_W) ? FW : LIMIT_W;
   localparam int MW = (CW > MATCH_W) ? CW : MATCH_W;

   state_type          state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      scan_ff, scan_in;
   logic [OP_W-1:0]    op_ff, op_in;
   query_type          query_ff, query_in;

   logic               res_accepted_ff, res_accepted_in;
   logic               res_present_ff, res_present_in;
   packet_type         res_pkt_ff, res_pkt_in;
   logic [MATCH_W-1:0] res_match_ff, res_match_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic               rsp_accepted_ff;
   logic               rsp_present_ff;
   packet_type         rsp_pkt_ff;
   logic [MATCH_W-1:0] rsp_match_ff;

   cell_ctrl_type      ctrl;
   logic               load_en;
   logic [FW-1:0]      load_pos;
   logic [DEPTH-1:0]   cell_load;
   logic [DEPTH-1:0]   cell_valid;
   logic [DEPTH-1:0]   cell_hit;
   packet_type         cell_pkt [DEPTH];

   logic [LW-1:0]      limit_eff;
   logic [LW-1:0]      fill_ext;
   logic [MW-1:0]      count_ext;
   logic [MATCH_W-1:0] count_sat;

   always_comb begin
      limit_eff = LW'(limit_ff);
      if (limit_eff == '0) begin
         limit_eff = LW'(1);
      end else if (limit_eff > LW'(DEPTH)) begin
         limit_eff = LW'(DEPTH);
      end
      fill_ext  = LW'(fill_ff);
      count_ext = MW'(count_ff);
      count_sat = (count_ext > MW'(COUNT_MAX)) ? COUNT_MAX : count_ext[MATCH_W-1:0];
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_load[i] = load_en && (load_pos == FW'(i));
      if (i < DEPTH - 1) begin : g_mid
         dpfrc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .load       (cell_load[i]),
            .query      (query_ff),
            .next_valid (cell_valid[i+1]),
            .next_pkt   (cell_pkt[i+1]),
            .next_hit   (cell_hit[i+1]),
            .valid      (cell_valid[i]),
            .pkt        (cell_pkt[i]),
            .hit        (cell_hit[i])
         );
      end else begin : g_tail
         dpfrc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .load       (cell_load[i]),
            .query      (query_ff),
            .next_valid (1'b0),
            .next_pkt   ('0),
            .next_hit   (1'b0),
            .valid      (cell_valid[i]),
            .pkt        (cell_pkt[i]),
            .hit        (cell_hit[i])
         );
      end
   end

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      op_in           = op_ff;
      query_in        = query_ff;
      res_accepted_in = res_accepted_ff;
      res_present_in  = res_present_ff;
      res_pkt_in      = res_pkt_ff;
      res_match_in    = res_match_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_load        = 1'b0;
      ctrl            = '0;
      ctrl.count_mode = (op_ff == OP_COUNT);
      load_en         = 1'b0;
      load_pos        = fill_ff;
      req_if.ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               op_in                = req_if.operation;
               query_in.pkt.src     = req_if.src_id;
               query_in.pkt.dst     = req_if.dst_id;
               query_in.pkt.stamp   = req_if.stamp;
               query_in.range_start = req_if.range_start;
               query_in.range_end   = req_if.range_end;
               res_accepted_in      = 1'b0;
               res_present_in       = 1'b0;
               res_pkt_in           = '0;
               res_match_in         = '0;
               if (req_if.operation == OP_FORWARD) begin
                  if (fill_ff != '0) begin
                     res_present_in = 1'b1;
                     res_pkt_in     = cell_pkt[0];
                     ctrl.shift     = 1'b1;
                     fill_in        = fill_ff - FW'(1);
                  end
                  state_in = ST_FINISH;
               end else if (req_if.operation == OP_ADD || req_if.operation == OP_COUNT) begin
                  state_in = ST_COMPARE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_COMPARE: begin
            ctrl.capture = 1'b1;
            count_in     = '0;
            scan_in      = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            ctrl.hit_shift = 1'b1;
            count_in       = count_ff + CW'(cell_hit[0]);
            scan_in        = scan_ff + SW'(1);
            if (scan_ff == SW'(DEPTH - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (op_ff == OP_ADD) begin
               res_accepted_in = (count_ff == '0);
               if (count_ff == '0) begin
                  load_en = 1'b1;
                  if (fill_ext >= limit_eff) begin
                     ctrl.shift = 1'b1;
                     load_pos   = fill_ff - FW'(1);
                  end else begin
                     fill_in = fill_ff + FW'(1);
                  end
               end
            end else begin
               res_match_in = count_sat;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      scan_ff         <= scan_in;
      op_ff           <= op_in;
      query_ff        <= query_in;
      res_accepted_ff <= res_accepted_in;
      res_present_ff  <= res_present_in;
      res_pkt_ff      <= res_pkt_in;
      res_match_ff    <= res_match_in;
      if (rsp_load) begin
         rsp_accepted_ff <= res_accepted_ff;
         rsp_present_ff  <= res_present_ff;
         rsp_pkt_ff      <= res_pkt_ff;
         rsp_match_ff    <= res_match_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.accepted    = rsp_accepted_ff;
   assign rsp_if.present     = rsp_present_ff;
   assign rsp_if.out_src     = rsp_pkt_ff.src;
   assign rsp_if.out_dst     = rsp_pkt_ff.dst;
   assign rsp_if.out_stamp   = rsp_pkt_ff.stamp;
   assign rsp_if.match_count = rsp_match_ff;

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill level exceeds the number of cells");

   assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(fill_ff))
      else $error("occupied cells disagree with the fill level");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && op_ff == OP_ADD && count_ff == '0) |=> fill_ff != '0)
      else $error("accepted add left the FIFO empty");

endmodule

`default_nettype wire

// File: tb/sv/dpfrc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet FIFO result checker
// Watches the request, response and CSR ports of the packet FIFO, keeps its
// own copy of the stored packets and the limit, works out the result of every
// accepted command and compares each response transfer with the oldest result
// still awaited.
// ----------------------------------------------------------------------------

module dpfrc_result_checker
   import dpfrc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   dpfrc_req_if               req,
   dpfrc_rsp_if               rsp,
   output int                 mismatches,
   output int                 pending_count
);

   typedef struct packed {
      logic               accepted;
      logic               present;
      logic [ID_W-1:0]    src;
      logic [ID_W-1:0]    dst;
      logic [STAMP_W-1:0] stamp;
      logic [MATCH_W-1:0] count;
   } outcome_type;

   logic [ID_W-1:0]    held_src   [DEPTH];
   logic [ID_W-1:0]    held_dst   [DEPTH];
   logic [STAMP_W-1:0] held_stamp [DEPTH];
   int                 held_count;
   int                 head_slot;
   int                 error_total;
   logic [LIMIT_W-1:0] limit_reg;
   outcome_type        awaited_results [$];
   outcome_type        wanted;

   function automatic int slot_of(input int k);
      return (head_slot + k) % DEPTH;
   endfunction

   function automatic int active_limit();
      int lim;
      lim = int'(limit_reg);
      if (lim == 0) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      return lim;
   endfunction

   function automatic outcome_type apply_command(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] src, dst,
                                                 input logic [STAMP_W-1:0] stamp, lo, hi);
      outcome_type r;
      logic        dup;
      int          n;
      int          s;
      r   = '0;
      dup = 1'b0;
      n   = 0;
      case (op)
         OP_ADD: begin
            for (int k = 0; k < held_count; k++) begin
               s = slot_of(k);
               if (held_src[s] == src && held_dst[s] == dst && held_stamp[s] == stamp)
                  dup = 1'b1;
            end
            if (!dup) begin
               if (held_count >= active_limit()) begin
                  head_slot = (head_slot + 1) % DEPTH;
                  held_count--;
               end
               s = slot_of(held_count);
               held_src[s]   = src;
               held_dst[s]   = dst;
               held_stamp[s] = stamp;
               held_count++;
               r.accepted = 1'b1;
            end
         end
         OP_FORWARD: begin
            if (held_count != 0) begin
               r.present = 1'b1;
               r.src     = held_src[head_slot];
               r.dst     = held_dst[head_slot];
               r.stamp   = held_stamp[head_slot];
               head_slot = (head_slot + 1) % DEPTH;
               held_count--;
            end
         end
         OP_COUNT: begin
            for (int k = 0; k < held_count; k++) begin
               s = slot_of(k);
               if (held_dst[s] == dst && held_stamp[s] >= lo && held_stamp[s] <= hi)
                  n++;
            end
            r.count = (n > COUNT_MAX) ? COUNT_MAX : n[MATCH_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [STAMP_W-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         head_slot  = 0;
         limit_reg  = LIMIT_RESET;
         awaited_results.delete();
      end else begin
         if (csr_write_enable) limit_reg = csr_write_data;
         if (rsp.valid && rsp.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response transfer with no command outstanding");
               error_total++;
            end else begin
               wanted = awaited_results.pop_front();
               check_field("accepted", STAMP_W'(wanted.accepted), STAMP_W'(rsp.accepted));
               check_field("present", STAMP_W'(wanted.present), STAMP_W'(rsp.present));
               check_field("out_src", STAMP_W'(wanted.src), STAMP_W'(rsp.out_src));
               check_field("out_dst", STAMP_W'(wanted.dst), STAMP_W'(rsp.out_dst));
               check_field("out_stamp", wanted.stamp, rsp.out_stamp);
               check_field("match_count", STAMP_W'(wanted.count),
                           STAMP_W'(rsp.match_count));
            end
         end
         if (req.valid && req.ready)
            awaited_results.insert(awaited_results.size(),
                                   apply_command(req.operation, req.src_id, req.dst_id,
                                                 req.stamp, req.range_start,
                                                 req.range_end));
      end
      pending_count <= awaited_results.size();
      mismatches    <= error_total;
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet FIFO testbench top
// Drives directed and random add, forward, count and unknown commands through
// the packet FIFO under several packet limits, with random idle bursts on both
// channels, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------

module tb_top;
   import dpfrc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int              STALL_MAX  = 6;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [LIMIT_W-1:0] csr_write_data;
   int                 idle_pct;
   int                 stall_left;
   int                 mismatches;
   int                 pending_count;

   dpfrc_req_if req_ch ();
   dpfrc_rsp_if rsp_ch ();

   dedup_packet_fifo_range_count_core #(
      .DEPTH(DEPTH_DEFAULT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch)
   );

   dpfrc_result_checker #(
      .DEPTH(DEPTH_DEFAULT)
   ) u_result_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .mismatches      (mismatches),
      .pending_count   (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, STALL_MAX - 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 15))
         0:       return ID_W'($urandom);
         1:       return '1;
         2:       return '0;
         default: return ID_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [STAMP_W-1:0] pick_stamp();
      case ($urandom_range(0, 15))
         0:       return $urandom;
         1:       return '1;
         2:       return '0;
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] src, dst,
                            input logic [STAMP_W-1:0] stamp, lo, hi);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, STALL_MAX)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.src_id      <= src;
      req_ch.dst_id      <= dst;
      req_ch.stamp       <= stamp;
      req_ch.range_start <= lo;
      req_ch.range_end   <= hi;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_random(input int add_pct, input int fwd_pct);
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [STAMP_W-1:0] lo;
      logic [STAMP_W-1:0] hi;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) op = OP_ADD;
      else if (pick < add_pct + fwd_pct) op = OP_FORWARD;
      else if (pick < 97) op = OP_COUNT;
      else op = OP_UNKNOWN;
      case ($urandom_range(0, 3))
         0: begin
            lo = $urandom;
            hi = $urandom;
         end
         1: begin
            lo = '0;
            hi = '1;
         end
         default: begin
            lo = pick_stamp();
            hi = pick_stamp();
         end
      endcase
      send_item(op, pick_id(), pick_id(), pick_stamp(), lo, hi);
   endtask

   // The sender holds off until the checker has seen every awaited result.
   task automatic settle();
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int items,
                            input int add_pct, input int fwd_pct, input int pace);
      write_limit(limit);
      idle_pct = pace;
      repeat (items) send_random(add_pct, fwd_pct);
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_ADD;
      req_ch.src_id      = '0;
      req_ch.dst_id      = '0;
      req_ch.stamp       = '0;
      req_ch.range_start = '0;
      req_ch.range_end   = '0;
      rsp_ch.ready       = 1'b0;
      idle_pct           = 0;
      stall_left         = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset    <= 1'b0;
      idle_pct = 10;

      send_item(OP_FORWARD, '0, '0, '0, '0, '0);
      send_item(OP_COUNT, '0, '0, '0, '0, '1);
      send_item(OP_UNKNOWN, '1, '1, '1, '1, '1);
      send_item(OP_ADD, '0, '0, '0, '0, '0);
      send_item(OP_ADD, '1, '1, '1, '0, '0);
      // A duplicate of the oldest packet is refused and nothing is dropped.
      send_item(OP_ADD, '0, '0, '0, '0, '0);
      send_item(OP_ADD, 16'h1234, '1, 32'd100, '0, '0);
      send_item(OP_ADD, '0, '1, 32'd100, '0, '0);
      send_item(OP_COUNT, '0, '1, '0, '0, '1);
      send_item(OP_COUNT, '0, '1, '0, 32'd100, 32'd100);
      send_item(OP_COUNT, '0, '1, '0, '1, '1);
      send_item(OP_COUNT, '0, '1, '0, 32'd200, 32'd50);
      send_item(OP_COUNT, '0, '0, '0, '0, '0);
      send_item(OP_FORWARD, '1, '1, '1, '1, '1);
      send_item(OP_FORWARD, '0, '0, '0, '0, '0);
      send_item(OP_ADD, '0, '0, '0, '0, '0);

      // A limit of zero behaves as a limit of one.
      write_limit('0);
      send_item(OP_ADD, 16'd1, 16'd1, 32'd1, '0, '0);
      send_item(OP_ADD, 16'd2, 16'd2, 32'd2, '0, '0);
      send_item(OP_ADD, 16'd2, 16'd2, 32'd2, '0, '0);
      send_item(OP_FORWARD, '0, '0, '0, '0, '0);
      send_item(OP_FORWARD, '0, '0, '0, '0, '0);

      run_phase(7'd64, 300, 60, 15, 15);
      run_phase(7'd3, 200, 40, 30, 12);
      run_phase(7'd0, 150, 40, 30, 0);
      run_phase(7'd127, 300, 60, 10, 15);
      run_phase(7'd1, 150, 45, 25, 10);
      run_phase(7'd17, 125, 45, 30, 12);
      settle();
      repeat (125) send_random(45, 30);
      run_phase(7'd64, 300, 55, 20, 15);

      idle_pct = 0;
      repeat (150) send_random(50, 25);

      settle();
      repeat (DEPTH_DEFAULT + 8) @(posedge clock);
      if (mismatches == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
